// ===== src/pef_pkg.sv =====
// Shared types, constants and helper functions for the packet echo filter.
// Used by pef_cell, pef_chain and packet_echo_filter_fnv1a. No dependencies.
package pef_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam int SENT_DEPTH_DEF       = 16;
    localparam int MAX_PACKET_BYTES_DEF = 255;

    localparam logic KIND_HEX     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;

    localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
    localparam logic [2:0] VERDICT_ECHO   = 3'd1;
    localparam logic [2:0] VERDICT_ODD    = 3'd2;
    localparam logic [2:0] VERDICT_LONG   = 3'd3;
    localparam logic [2:0] VERDICT_BADHEX = 3'd4;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Lookup query traveling down the hash chain.
    typedef struct packed {
        logic        vld;
        logic        hit;
        logic [31:0] key;
    } t_query;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    function automatic logic [7:0] hex_of(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

    // Bit 4 set when the character is a valid hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== src/packet_echo_filter_fnv1a.sv =====
// Packet echo filter with 32-bit FNV-1a hashing: control, hash accumulators
// and output register. Depends on pef_pkg and pef_chain.
//
// Input channel (i_in_valid / o_in_ready): i_op = 0 carries a raw outgoing
// byte, i_op = 1 an incoming ASCII hex character; i_last_in closes a packet.
// Output channel (o_out_valid / i_out_ready): one beat per result.
// An outgoing byte gives two hex character beats; the
// second beat of a last byte carries the packet hash, whose hash is also
// pushed into the chain of SENT_DEPTH recent sent hashes.
// An incoming character that is not last gives no beat.
// A last incoming character gives one verdict beat, set by the query
// walking the hash chain one cell per cycle.
// Reset clears the chain to zero hashes and restarts both accumulators.
// When the receiver stalls, the result is held in the output register and
// o_in_ready stays low until that register can take the next beat.
module packet_echo_filter_fnv1a #(
    parameter int SENT_DEPTH       = pef_pkg::SENT_DEPTH_DEF,
    parameter int MAX_PACKET_BYTES = pef_pkg::MAX_PACKET_BYTES_DEF,
    localparam int BYTES_W         = $clog2(MAX_PACKET_BYTES + 2)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [7:0]         i_data_in,
    input  logic               i_last_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [7:0]         o_hex_char,
    output logic [2:0]         o_verdict,
    output logic [BYTES_W-1:0] o_byte_count,
    output logic [31:0]        o_packet_hash,
    output logic               o_run_last,
    output logic               o_packet_end
);
    import pef_pkg::*;

    localparam int CNT_SAT = 2 * MAX_PACKET_BYTES + 2;
    localparam int CNT_W   = $clog2(CNT_SAT + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_TX2    = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WAIT   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_tx_hash, n_tx_hash;
    logic [31:0]        r_rx_hash, n_rx_hash;
    logic [CNT_W-1:0]   r_rx_cnt, n_rx_cnt;
    logic [3:0]         r_rx_hi, n_rx_hi;
    logic               r_rx_bad, n_rx_bad;
    logic               r_rx_odd, n_rx_odd;
    logic               r_hit, n_hit;

    logic [7:0]         r_pend_char, n_pend_char;
    logic [31:0]        r_pend_hash, n_pend_hash;
    logic               r_pend_end, n_pend_end;

    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [7:0]         r_hex, n_hex;
    logic [2:0]         r_verdict, n_verdict;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [31:0]        r_hash, n_hash;
    logic               r_rl, n_rl;
    logic               r_pe, n_pe;

    logic               w_out_free;
    logic               w_accept;
    logic [4:0]         w_nib;
    logic [31:0]        w_mul_h;
    logic [7:0]         w_mul_b;
    logic [31:0]        w_mul;
    logic [BYTES_W-1:0] w_bytes;
    logic               w_push;
    t_query             w_q_in;
    t_query             w_q_out;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_nib   = nibble_of(i_data_in);
    assign w_mul_h = (i_op == OP_RX) ? r_rx_hash : r_tx_hash;
    assign w_mul_b = (i_op == OP_RX) ? {r_rx_hi, w_nib[3:0]} : i_data_in;
    assign w_mul   = fnv_step(w_mul_h, w_mul_b);
    assign w_bytes = BYTES_W'(r_rx_cnt >> 1);

    assign w_push = w_accept && (i_op == OP_TX) && i_last_in;
    assign w_q_in = '{vld: (r_state == S_LAUNCH), hit: 1'b0, key: r_rx_hash};

    pef_chain #(
        .SENT_DEPTH (SENT_DEPTH)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_hash (w_mul),
        .i_query     (w_q_in),
        .o_query     (w_q_out)
    );

    always_comb begin
        n_state     = r_state;
        n_tx_hash   = r_tx_hash;
        n_rx_hash   = r_rx_hash;
        n_rx_cnt    = r_rx_cnt;
        n_rx_hi     = r_rx_hi;
        n_rx_bad    = r_rx_bad;
        n_rx_odd    = r_rx_odd;
        n_hit       = r_hit;
        n_pend_char = r_pend_char;
        n_pend_hash = r_pend_hash;
        n_pend_end  = r_pend_end;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_hex       = r_hex;
        n_verdict   = r_verdict;
        n_bytes     = r_bytes;
        n_hash      = r_hash;
        n_rl        = r_rl;
        n_pe        = r_pe;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_TX) begin
                        n_tx_hash   = i_last_in ? FNV_BASIS : w_mul;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_HEX;
                        n_hex       = hex_of(i_data_in[7:4]);
                        n_verdict   = VERDICT_ACCEPT;
                        n_bytes     = '0;
                        n_hash      = '0;
                        n_rl        = 1'b0;
                        n_pe        = 1'b0;
                        n_pend_char = hex_of(i_data_in[3:0]);
                        n_pend_hash = i_last_in ? w_mul : 32'd0;
                        n_pend_end  = i_last_in;
                        n_state     = S_TX2;
                    end else begin
                        if (!w_nib[4]) begin
                            n_rx_bad = 1'b1;
                        end
                        if (!r_rx_odd) begin
                            n_rx_hi = w_nib[3:0];
                        end else begin
                            n_rx_hash = w_mul;
                        end
                        n_rx_odd = !r_rx_odd;
                        if (r_rx_cnt < CNT_W'(CNT_SAT)) begin
                            n_rx_cnt = r_rx_cnt + 1'b1;
                        end
                        if (i_last_in) begin
                            n_state = S_LAUNCH;
                        end
                    end
                end
            end
            S_TX2: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_HEX;
                    n_hex       = r_pend_char;
                    n_verdict   = VERDICT_ACCEPT;
                    n_bytes     = '0;
                    n_hash      = r_pend_hash;
                    n_rl        = 1'b1;
                    n_pe        = r_pend_end;
                    n_state     = S_IDLE;
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_q_out.vld) begin
                    n_hit   = w_q_out.hit;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_VERDICT;
                    n_hex       = 8'd0;
                    n_bytes     = w_bytes;
                    n_hash      = r_rx_hash;
                    n_rl        = 1'b1;
                    n_pe        = 1'b1;
                    if (r_rx_odd) begin
                        n_verdict = VERDICT_ODD;
                    end else if (w_bytes > BYTES_W'(MAX_PACKET_BYTES)) begin
                        n_verdict = VERDICT_LONG;
                    end else if (r_rx_bad) begin
                        n_verdict = VERDICT_BADHEX;
                    end else if (r_hit) begin
                        n_verdict = VERDICT_ECHO;
                    end else begin
                        n_verdict = VERDICT_ACCEPT;
                    end
                    n_rx_hash = FNV_BASIS;
                    n_rx_cnt  = '0;
                    n_rx_hi   = 4'd0;
                    n_rx_bad  = 1'b0;
                    n_rx_odd  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tx_hash   <= FNV_BASIS;
            r_rx_hash   <= FNV_BASIS;
            r_rx_cnt    <= '0;
            r_rx_hi     <= 4'd0;
            r_rx_bad    <= 1'b0;
            r_rx_odd    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tx_hash   <= n_tx_hash;
            r_rx_hash   <= n_rx_hash;
            r_rx_cnt    <= n_rx_cnt;
            r_rx_hi     <= n_rx_hi;
            r_rx_bad    <= n_rx_bad;
            r_rx_odd    <= n_rx_odd;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_char <= n_pend_char;
        r_pend_hash <= n_pend_hash;
        r_pend_end  <= n_pend_end;
        r_kind      <= n_kind;
        r_hex       <= n_hex;
        r_verdict   <= n_verdict;
        r_bytes     <= n_bytes;
        r_hash      <= n_hash;
        r_rl        <= n_rl;
        r_pe        <= n_pe;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_hex_char    = r_hex;
    assign o_verdict     = r_verdict;
    assign o_byte_count  = r_bytes;
    assign o_packet_hash = r_hash;
    assign o_run_last    = r_rl;
    assign o_packet_end  = r_pe;

endmodule

// ===== src/pef_cell.sv =====
// One cell of the sent-hash chain: holds one hash, shifts it on push,
// and checks the passing query against it. Depends on pef_pkg.
module pef_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [31:0]     i_hash,
    output logic [31:0]     o_hash,
    input  pef_pkg::t_query i_query,
    output pef_pkg::t_query o_query
);
    import pef_pkg::*;

    logic [31:0] r_hash;
    t_query      r_query;
    t_query      n_query;

    always_comb begin
        n_query     = i_query;
        n_query.hit = i_query.hit | (i_query.key == r_hash);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_query.vld <= 1'b0;
            r_query.hit <= 1'b0;
            r_query.key <= '0;
        end else begin
            if (i_push) begin
                r_hash <= i_hash;
            end
            r_query <= n_query;
        end
    end

    assign o_hash  = r_hash;
    assign o_query = r_query;

endmodule

// ===== src/pef_chain.sv =====
// Row of SENT_DEPTH hash cells: a push shifts a new hash in at the head,
// a query walks one cell per cycle. Depends on pef_pkg and pef_cell.
module pef_chain #(
    parameter int SENT_DEPTH = pef_pkg::SENT_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [31:0]     i_push_hash,
    input  pef_pkg::t_query i_query,
    output pef_pkg::t_query o_query
);
    import pef_pkg::*;

    logic [31:0] w_hash  [SENT_DEPTH+1];
    t_query      w_query [SENT_DEPTH+1];

    assign w_hash[0]  = i_push_hash;
    assign w_query[0] = i_query;

    for (genvar g = 0; g < SENT_DEPTH; g++) begin : g_cell
        pef_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_push  (i_push),
            .i_hash  (w_hash[g]),
            .o_hash  (w_hash[g+1]),
            .i_query (w_query[g]),
            .o_query (w_query[g+1])
        );
    end

    assign o_query = w_query[SENT_DEPTH];

endmodule
